### hw/rtl/fse_pkg.sv
// ----------------------------------------------------------------------------
// Flow set encoder package
// Shared constants, operation codes and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int FILTER_HASHES_DEF   = 4;
  localparam int FILTER_SIZE_DEF     = 4096;
  localparam int TABLE_HASHES_DEF    = 3;
  localparam int SUB_TABLE_DEPTH_DEF = 1024;

  localparam int KEY_BYTES        = 13;
  localparam int FLOW_COUNT_LIMIT = 256;
  localparam logic [7:0] FLOW_COUNT_MAX = 8'(FLOW_COUNT_LIMIT - 1);

  localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2 = 32'h1b873593;
  localparam logic [31:0] MUR_E  = 32'he6546b64;
  localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef struct packed {
    logic latch;
    logic clear_step;
    logic hash_start;
    logic lane_save;
    logic filt_rd;
    logic filt_upd;
    logic seed_inc;
    logic tbl_clr;
    logic tbl_rd;
    logic tbl_wr;
    logic tbl_inc;
    logic ent_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  clear_last;
    logic  hash_done;
    logic  filt_use;
    logic  seed_last;
    logic  tbl_last;
  } stat_t;

endpackage

### hw/rtl/fse_hash.sv
// ----------------------------------------------------------------------------
// Flow set encoder hash unit
// 32-bit murmur3 over the 13-byte flow key with one shared multiplier, one
// step a cycle, followed by two constant remainders at four bits a cycle.
// ----------------------------------------------------------------------------
module fse_hash
  import fse_pkg::*;
#(
  parameter int FILTER_SIZE     = FILTER_SIZE_DEF,
  parameter int SUB_TABLE_DEPTH = SUB_TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [31:0]                        seed,
  input  logic [31:0]                        src_ip,
  input  logic [31:0]                        dst_ip,
  input  logic [15:0]                        src_port,
  input  logic [15:0]                        dst_port,
  input  logic [7:0]                         ip_protocol,
  output logic                               done,
  output logic [$clog2(FILTER_SIZE)-1:0]     filt_idx,
  output logic [$clog2(SUB_TABLE_DEPTH)-1:0] sub_idx
);

  localparam int FW = $clog2(FILTER_SIZE);
  localparam int SW = $clog2(SUB_TABLE_DEPTH);
  localparam int MOD_BITS = 4;
  localparam int MOD_STEPS = 32 / MOD_BITS;
  localparam logic [3:0] LAST_MIX = 4'd12;
  localparam logic [FW:0] FMOD = (FW + 1)'(FILTER_SIZE);
  localparam logic [SW:0] SMOD = (SW + 1)'(SUB_TABLE_DEPTH);

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MOD} hstate_t;

  hstate_t     state;
  logic [3:0]  step;
  logic [2:0]  mcnt;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] q;
  logic [FW-1:0] rf;
  logic [SW-1:0] rs;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] x;
  logic [31:0] h_round;
  logic [FW-1:0] rf_next;
  logic [SW-1:0] rs_next;
  logic [FW:0]   tf;
  logic [SW:0]   ts;

  always_comb begin
    mul_a = 32'd0;
    mul_b = MUR_C1;
    x = h ^ k;
    case (step)
      4'd0: mul_a = src_ip;
      4'd3: mul_a = dst_ip;
      4'd6: mul_a = {dst_port, src_port};
      4'd9: mul_a = {24'd0, ip_protocol};
      4'd1, 4'd4, 4'd7, 4'd10: begin
        mul_a = {k[16:0], k[31:17]};
        mul_b = MUR_C2;
      end
      4'd11: begin
        x = h ^ k ^ 32'(KEY_BYTES);
        x = x ^ (x >> 16);
        mul_a = x;
        mul_b = MUR_F1;
      end
      4'd12: begin
        x = h ^ (h >> 13);
        mul_a = x;
        mul_b = MUR_F2;
      end
      default: begin
        mul_a = 32'd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    logic [31:0] r13;
    r13 = {x[18:0], x[31:19]};
    h_round = (r13 << 2) + r13 + MUR_E;
  end

  always_comb begin
    rf_next = rf;
    rs_next = rs;
    tf = '0;
    ts = '0;
    for (int j = 0; j < MOD_BITS; j++) begin
      tf = {rf_next, q[31 - j]};
      if (tf >= FMOD) begin
        tf = tf - FMOD;
      end
      rf_next = tf[FW-1:0];
      ts = {rs_next, q[31 - j]};
      if (ts >= SMOD) begin
        ts = ts - SMOD;
      end
      rs_next = ts[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done <= 1'b0;
      step <= 4'd0;
      mcnt <= 3'd0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (start) begin
            h <= seed;
            step <= 4'd0;
            state <= H_MIX;
          end
        end
        H_MIX: begin
          case (step)
            4'd2, 4'd5, 4'd8: h <= h_round;
            4'd11: h <= prod;
            default: k <= prod;
          endcase
          if (step == LAST_MIX) begin
            q <= prod ^ (prod >> 16);
            rf <= '0;
            rs <= '0;
            mcnt <= 3'd0;
            state <= H_MOD;
          end else begin
            step <= step + 4'd1;
          end
        end
        H_MOD: begin
          rf <= rf_next;
          rs <= rs_next;
          q <= q << MOD_BITS;
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'(MOD_STEPS - 1)) begin
            done <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign filt_idx = rf;
  assign sub_idx = rs;

endmodule

### hw/rtl/fse_datapath.sv
// ----------------------------------------------------------------------------
// Flow set encoder datapath
// Operand registers, the hash unit, the filter and count table memories,
// the clearing sweep and the result registers.
// ----------------------------------------------------------------------------
module fse_datapath
  import fse_pkg::*;
#(
  parameter int FILTER_HASHES   = FILTER_HASHES_DEF,
  parameter int FILTER_SIZE     = FILTER_SIZE_DEF,
  parameter int TABLE_HASHES    = TABLE_HASHES_DEF,
  parameter int SUB_TABLE_DEPTH = SUB_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  func,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  ip_protocol,
  input  logic [11:0] entry_index,
  output logic        is_new_flow,
  output logic        flow_present,
  output logic [31:0] xor_src_ip,
  output logic [31:0] xor_dst_ip,
  output logic [15:0] xor_src_port,
  output logic [15:0] xor_dst_port,
  output logic [7:0]  xor_protocol,
  output logic [7:0]  flow_count,
  output logic [31:0] packet_count
);

  localparam int NH = (FILTER_HASHES > TABLE_HASHES) ? FILTER_HASHES : TABLE_HASHES;
  localparam int SDW = (NH > 1) ? $clog2(NH) : 1;
  localparam int LW = (TABLE_HASHES > 1) ? $clog2(TABLE_HASHES) : 1;
  localparam int FW = $clog2(FILTER_SIZE);
  localparam int SW = $clog2(SUB_TABLE_DEPTH);
  localparam int ENTRIES = TABLE_HASHES * SUB_TABLE_DEPTH;
  localparam int EW = $clog2(ENTRIES);
  localparam int CLEAR_LEN = (FILTER_SIZE > ENTRIES) ? FILTER_SIZE : ENTRIES;
  localparam int CW = $clog2(CLEAR_LEN);

  typedef struct packed {
    logic [63:0] addr;
    logic [39:0] ports;
    logic [7:0]  fcount;
    logic [31:0] pcount;
  } entry_t;

  func_t       func_q;
  logic [31:0] sip_q;
  logic [31:0] dip_q;
  logic [15:0] sp_q;
  logic [15:0] dp_q;
  logic [7:0]  pr_q;
  logic [11:0] eidx_q;
  logic        new_flag;
  logic        present_flag;
  logic [SDW-1:0] seed;
  logic [LW-1:0]  tc;
  logic [CW-1:0]  clr_addr;
  logic [EW-1:0]  lane [TABLE_HASHES];

  logic          filt_mem [FILTER_SIZE];
  logic          filt_q;
  entry_t        tbl_mem [ENTRIES];
  entry_t        tbl_q;
  entry_t        tbl_new;

  logic          hash_done;
  logic [FW-1:0] filt_idx;
  logic [SW-1:0] sub_idx;
  logic [EW-1:0] tbl_addr;
  logic [EW-1:0] ent_addr;
  logic          eidx_ok;
  logic          xor_in;

  fse_hash #(
    .FILTER_SIZE     (FILTER_SIZE),
    .SUB_TABLE_DEPTH (SUB_TABLE_DEPTH)
  ) u_hash (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.hash_start),
    .seed        (32'(seed)),
    .src_ip      (sip_q),
    .dst_ip      (dip_q),
    .src_port    (sp_q),
    .dst_port    (dp_q),
    .ip_protocol (pr_q),
    .done        (hash_done),
    .filt_idx    (filt_idx),
    .sub_idx     (sub_idx)
  );

  assign tbl_addr = lane[tc];
  assign ent_addr = EW'(eidx_q);
  assign eidx_ok = 32'(eidx_q) < ENTRIES;
  assign xor_in = ((func_q == FUNC_UPDATE) && new_flag) || (func_q == FUNC_REMOVE);

  always_comb begin
    stat.func = func_q;
    stat.clear_last = (clr_addr == CW'(CLEAR_LEN - 1));
    stat.hash_done = hash_done;
    stat.filt_use = (func_q != FUNC_REMOVE) && (32'(seed) < FILTER_HASHES);
    stat.seed_last = (seed == SDW'(NH - 1));
    stat.tbl_last = (tc == LW'(TABLE_HASHES - 1));
  end

  always_comb begin
    tbl_new = tbl_q;
    if (xor_in) begin
      tbl_new.addr = tbl_q.addr ^ {dip_q, sip_q};
      tbl_new.ports = tbl_q.ports ^ {pr_q, dp_q, sp_q};
    end
    if ((func_q == FUNC_UPDATE) && new_flag && (tbl_q.fcount != FLOW_COUNT_MAX)) begin
      tbl_new.fcount = tbl_q.fcount + 8'd1;
    end else if ((func_q == FUNC_REMOVE) && (tbl_q.fcount != 8'd0)) begin
      tbl_new.fcount = tbl_q.fcount - 8'd1;
    end
    if (func_q == FUNC_UPDATE) begin
      tbl_new.pcount = tbl_q.pcount + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      seed <= '0;
      tc <= '0;
      new_flag <= 1'b0;
      present_flag <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + CW'(1);
      end
      if (cmd.latch) begin
        seed <= '0;
        new_flag <= 1'b0;
        present_flag <= 1'b1;
      end
      if (cmd.seed_inc) begin
        seed <= seed + SDW'(1);
      end
      if (cmd.tbl_clr) begin
        tc <= '0;
      end
      if (cmd.tbl_inc) begin
        tc <= tc + LW'(1);
      end
      if (cmd.filt_upd && !filt_q) begin
        present_flag <= 1'b0;
        if (func_q == FUNC_UPDATE) begin
          new_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func_t'(func);
      sip_q <= src_ip;
      dip_q <= dst_ip;
      sp_q <= src_port;
      dp_q <= dst_port;
      pr_q <= ip_protocol;
      eidx_q <= entry_index;
    end
    if (cmd.lane_save && (32'(seed) < TABLE_HASHES)) begin
      lane[seed[LW-1:0]] <= EW'(32'(seed) * 32'(SUB_TABLE_DEPTH)) + EW'(sub_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && (32'(clr_addr) < FILTER_SIZE)) begin
      filt_mem[clr_addr[FW-1:0]] <= 1'b0;
    end else if (cmd.filt_upd && (func_q == FUNC_UPDATE)) begin
      filt_mem[filt_idx] <= 1'b1;
    end
    if (cmd.filt_rd) begin
      filt_q <= filt_mem[filt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && (32'(clr_addr) < ENTRIES)) begin
      tbl_mem[clr_addr[EW-1:0]] <= '0;
    end else if (cmd.tbl_wr) begin
      tbl_mem[tbl_addr] <= tbl_new;
    end
    if (cmd.ent_rd) begin
      tbl_q <= tbl_mem[ent_addr];
    end else if (cmd.tbl_rd) begin
      tbl_q <= tbl_mem[tbl_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      is_new_flow <= (func_q == FUNC_UPDATE) && new_flag;
      flow_present <= (func_q == FUNC_QUERY) && present_flag;
      if ((func_q == FUNC_READ) && eidx_ok) begin
        xor_src_ip <= tbl_q.addr[31:0];
        xor_dst_ip <= tbl_q.addr[63:32];
        xor_src_port <= tbl_q.ports[15:0];
        xor_dst_port <= tbl_q.ports[31:16];
        xor_protocol <= tbl_q.ports[39:32];
        flow_count <= tbl_q.fcount;
        packet_count <= tbl_q.pcount;
      end else begin
        xor_src_ip <= 32'd0;
        xor_dst_ip <= 32'd0;
        xor_src_port <= 16'd0;
        xor_dst_port <= 16'd0;
        xor_protocol <= 8'd0;
        flow_count <= 8'd0;
        packet_count <= 32'd0;
      end
    end
  end

endmodule

### hw/rtl/fse_ctrl.sv
// ----------------------------------------------------------------------------
// Flow set encoder controller
// Sequences the clearing sweep, the per-hash filter work, the count table
// read-modify-write passes, the entry read for table reads and the result strobe.
// ----------------------------------------------------------------------------
module fse_ctrl
  import fse_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_GO,
    S_HASH_WAIT,
    S_FILT_RD,
    S_FILT_WR,
    S_SEED_NEXT,
    S_TBL_RD,
    S_TBL_WR,
    S_ENT_RD,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = S_HASH_GO;
        end
      end
      S_HASH_GO: begin
        if (stat.func == FUNC_READ) begin
          cmd.ent_rd = 1'b1;
          state_next = S_ENT_RD;
        end else begin
          cmd.hash_start = 1'b1;
          state_next = S_HASH_WAIT;
        end
      end
      S_HASH_WAIT: begin
        if (stat.hash_done) begin
          cmd.lane_save = 1'b1;
          state_next = stat.filt_use ? S_FILT_RD : S_SEED_NEXT;
        end
      end
      S_FILT_RD: begin
        cmd.filt_rd = 1'b1;
        state_next = S_FILT_WR;
      end
      S_FILT_WR: begin
        cmd.filt_upd = 1'b1;
        state_next = S_SEED_NEXT;
      end
      S_SEED_NEXT: begin
        if (stat.seed_last) begin
          cmd.tbl_clr = 1'b1;
          state_next = (stat.func == FUNC_QUERY) ? S_DONE : S_TBL_RD;
        end else begin
          cmd.seed_inc = 1'b1;
          state_next = S_HASH_GO;
        end
      end
      S_TBL_RD: begin
        cmd.tbl_rd = 1'b1;
        state_next = S_TBL_WR;
      end
      S_TBL_WR: begin
        cmd.tbl_wr = 1'b1;
        if (stat.tbl_last) begin
          state_next = S_DONE;
        end else begin
          cmd.tbl_inc = 1'b1;
          state_next = S_TBL_RD;
        end
      end
      S_ENT_RD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
      done <= (state == S_DONE);
    end
  end

endmodule

### hw/rtl/flow_set_encoder.sv
// ----------------------------------------------------------------------------
// Flow set encoder
// Bloom filter of seen flows and an invertible count table with one
// sub-table per hash, keyed by the IPv4 five-tuple.
//
//   Channel   Handshake           Fields
//   command   start, busy         func, src_ip, dst_ip, src_port, dst_port,
//                                 ip_protocol, entry_index
//   result    done (one cycle)    is_new_flow, flow_present, xor_src_ip,
//                                 xor_dst_ip, xor_src_port, xor_dst_port,
//                                 xor_protocol, flow_count, packet_count
//
// A command is taken when start is high and busy is low; one result follows.
// Each hash number passes through the shared hash unit (13 mix steps on one
// multiplier, 8 remainder steps), and each table entry update is a read and
// then a write; a table read is an entry read followed by the result load.
// After reset, busy stays high while both memories are cleared.
// The receiver cannot stall: each transfer is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module flow_set_encoder
  import fse_pkg::*;
#(
  parameter int FILTER_HASHES   = FILTER_HASHES_DEF,
  parameter int FILTER_SIZE     = FILTER_SIZE_DEF,
  parameter int TABLE_HASHES    = TABLE_HASHES_DEF,
  parameter int SUB_TABLE_DEPTH = SUB_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  ip_protocol,
  input  logic [11:0] entry_index,
  output logic        done,
  output logic        is_new_flow,
  output logic        flow_present,
  output logic [31:0] xor_src_ip,
  output logic [31:0] xor_dst_ip,
  output logic [15:0] xor_src_port,
  output logic [15:0] xor_dst_port,
  output logic [7:0]  xor_protocol,
  output logic [7:0]  flow_count,
  output logic [31:0] packet_count
);

  cmd_t  cmd;
  stat_t stat;

  fse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fse_datapath #(
    .FILTER_HASHES   (FILTER_HASHES),
    .FILTER_SIZE     (FILTER_SIZE),
    .TABLE_HASHES    (TABLE_HASHES),
    .SUB_TABLE_DEPTH (SUB_TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .src_ip       (src_ip),
    .dst_ip       (dst_ip),
    .src_port     (src_port),
    .dst_port     (dst_port),
    .ip_protocol  (ip_protocol),
    .entry_index  (entry_index),
    .is_new_flow  (is_new_flow),
    .flow_present (flow_present),
    .xor_src_ip   (xor_src_ip),
    .xor_dst_ip   (xor_dst_ip),
    .xor_src_port (xor_src_port),
    .xor_dst_port (xor_dst_port),
    .xor_protocol (xor_protocol),
    .flow_count   (flow_count),
    .packet_count (packet_count)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow set encoder testbench
// Drives packet updates, membership queries, flow removals and table reads,
// predicts every result from a behavioural copy of the filter and the count
// table, and compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import fse_pkg::*;

  localparam int TBL_ENTRIES = TABLE_HASHES_DEF * SUB_TABLE_DEPTH_DEF;

  typedef struct {
    func_t       fn;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  pr;
    logic [11:0] idx;
  } flow_cmd_t;

  typedef struct {
    logic        is_new;
    logic        present;
    logic [31:0] xsip;
    logic [31:0] xdip;
    logic [15:0] xsp;
    logic [15:0] xdp;
    logic [7:0]  xpr;
    logic [7:0]  fcnt;
    logic [31:0] pcnt;
  } flow_res_t;

  class flow_scoreboard;
    bit          filt[FILTER_SIZE_DEF];
    bit [63:0]   addr_x[TBL_ENTRIES];
    bit [39:0]   port_x[TBL_ENTRIES];
    bit [7:0]    fcnt[TBL_ENTRIES];
    bit [31:0]   pcnt[TBL_ENTRIES];
    flow_res_t   pending[$];
    int          errors;
    int          checked;

    static function logic [31:0] mix(logic [31:0] k);
      logic [31:0] m;
      m = k * MUR_C1;
      m = {m[16:0], m[31:17]};
      return m * MUR_C2;
    endfunction

    static function logic [31:0] hash_of(flow_cmd_t c, int seed);
      logic [31:0] h;
      logic [31:0] blk[3];
      blk[0] = c.sip;
      blk[1] = c.dip;
      blk[2] = {c.dp, c.sp};
      h = 32'(seed);
      for (int b = 0; b < 3; b++) begin
        h ^= mix(blk[b]);
        h = {h[18:0], h[31:19]};
        h = h * 32'd5 + MUR_E;
      end
      h ^= mix({24'd0, c.pr});
      h ^= 32'(KEY_BYTES);
      h ^= h >> 16;
      h = h * MUR_F1;
      h ^= h >> 13;
      h = h * MUR_F2;
      h ^= h >> 16;
      return h;
    endfunction

    static function int entry_of(flow_cmd_t c, int seed);
      return seed * SUB_TABLE_DEPTH_DEF + int'(hash_of(c, seed) % SUB_TABLE_DEPTH_DEF);
    endfunction

    function void note(flow_cmd_t c);
      flow_res_t r;
      int        e;
      int        b;
      r = '{default: '0};
      case (c.fn)
        FUNC_UPDATE: begin
          for (int i = 0; i < FILTER_HASHES_DEF; i++) begin
            b = int'(hash_of(c, i) % FILTER_SIZE_DEF);
            if (!filt[b]) begin
              filt[b] = 1'b1;
              r.is_new = 1'b1;
            end
          end
          for (int i = 0; i < TABLE_HASHES_DEF; i++) begin
            e = entry_of(c, i);
            if (r.is_new) begin
              addr_x[e] ^= {c.dip, c.sip};
              port_x[e] ^= {c.pr, c.dp, c.sp};
              if (fcnt[e] != FLOW_COUNT_MAX) fcnt[e]++;
            end
            pcnt[e]++;
          end
        end
        FUNC_QUERY: begin
          r.present = 1'b1;
          for (int i = 0; i < FILTER_HASHES_DEF; i++)
            if (!filt[int'(hash_of(c, i) % FILTER_SIZE_DEF)]) r.present = 1'b0;
        end
        FUNC_REMOVE: begin
          for (int i = 0; i < TABLE_HASHES_DEF; i++) begin
            e = entry_of(c, i);
            addr_x[e] ^= {c.dip, c.sip};
            port_x[e] ^= {c.pr, c.dp, c.sp};
            if (fcnt[e] != 8'd0) fcnt[e]--;
          end
        end
        default: begin
          if (int'(c.idx) < TBL_ENTRIES) begin
            r.xsip = addr_x[c.idx][31:0];
            r.xdip = addr_x[c.idx][63:32];
            r.xsp  = port_x[c.idx][15:0];
            r.xdp  = port_x[c.idx][31:16];
            r.xpr  = port_x[c.idx][39:32];
            r.fcnt = fcnt[c.idx];
            r.pcnt = pcnt[c.idx];
          end
        end
      endcase
      pending = {pending, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task check(flow_res_t got);
      flow_res_t w;
      if (pending.size() == 0) begin
        report("result with nothing outstanding", 32'd0, 32'd0);
      end else begin
        w = pending.pop_front();
        checked++;
        field("is_new_flow", 32'(got.is_new), 32'(w.is_new));
        field("flow_present", 32'(got.present), 32'(w.present));
        field("xor_src_ip", got.xsip, w.xsip);
        field("xor_dst_ip", got.xdip, w.xdip);
        field("xor_src_port", 32'(got.xsp), 32'(w.xsp));
        field("xor_dst_port", 32'(got.xdp), 32'(w.xdp));
        field("xor_protocol", 32'(got.xpr), 32'(w.xpr));
        field("flow_count", 32'(got.fcnt), 32'(w.fcnt));
        field("packet_count", got.pcnt, w.pcnt);
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  ip_protocol;
  logic [11:0] entry_index;
  logic        done;
  logic        is_new_flow;
  logic        flow_present;
  logic [31:0] xor_src_ip;
  logic [31:0] xor_dst_ip;
  logic [15:0] xor_src_port;
  logic [15:0] xor_dst_port;
  logic [7:0]  xor_protocol;
  logic [7:0]  flow_count;
  logic [31:0] packet_count;

  flow_scoreboard sb;
  flow_cmd_t      pool[64];
  int             sent;
  bit             calm;
  int             hot_flows;

  flow_set_encoder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .src_ip(src_ip), .dst_ip(dst_ip), .src_port(src_port), .dst_port(dst_port),
    .ip_protocol(ip_protocol), .entry_index(entry_index), .done(done),
    .is_new_flow(is_new_flow), .flow_present(flow_present),
    .xor_src_ip(xor_src_ip), .xor_dst_ip(xor_dst_ip),
    .xor_src_port(xor_src_port), .xor_dst_port(xor_dst_port),
    .xor_protocol(xor_protocol), .flow_count(flow_count),
    .packet_count(packet_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check('{is_new_flow, flow_present, xor_src_ip, xor_dst_ip, xor_src_port,
                 xor_dst_port, xor_protocol, flow_count, packet_count});
  end

  function automatic flow_cmd_t random_flow(func_t f);
    flow_cmd_t c;
    c.fn  = f;
    c.sip = $urandom;
    c.dip = $urandom;
    c.sp  = 16'($urandom);
    c.dp  = 16'($urandom);
    c.pr  = 8'($urandom);
    c.idx = 12'($urandom);
    return c;
  endfunction

  function automatic flow_cmd_t with_func(flow_cmd_t c, func_t f, int idx);
    flow_cmd_t r;
    r     = c;
    r.fn  = f;
    r.idx = 12'(idx);
    return r;
  endfunction

  // Holds start high until the transfer is taken, then may leave a gap.
  task automatic send(flow_cmd_t c);
    func        <= c.fn;
    src_ip      <= c.sip;
    dst_ip      <= c.dip;
    src_port    <= c.sp;
    dst_port    <= c.dp;
    ip_protocol <= c.pr;
    entry_index <= c.idx;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note(c);
    sent++;
    if (!calm && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    flow_cmd_t a;
    flow_cmd_t z;
    flow_cmd_t c;
    int        pick;
    sb = new();
    sent = 0;
    calm = 1'b0;
    hot_flows = 0;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_UPDATE;
    src_ip = '0;
    dst_ip = '0;
    src_port = '0;
    dst_port = '0;
    ip_protocol = '0;
    entry_index = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    z = '{FUNC_UPDATE, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 12'h0};
    a = '{FUNC_UPDATE, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 8'hff, 12'hfff};
    send(with_func(z, FUNC_READ, 0));
    send(with_func(z, FUNC_READ, TBL_ENTRIES - 1));
    send(with_func(z, FUNC_QUERY, 0));
    send(z);
    send(a);
    send(a);
    send(with_func(a, FUNC_QUERY, 0));
    send(with_func(z, FUNC_QUERY, 0));
    send(with_func(random_flow(FUNC_QUERY), FUNC_QUERY, 0));
    for (int i = 0; i < TABLE_HASHES_DEF; i++)
      send(with_func(a, FUNC_READ, flow_scoreboard::entry_of(a, i)));
    send(with_func(a, FUNC_REMOVE, 0));
    send(with_func(a, FUNC_REMOVE, 0));
    for (int i = 0; i < TABLE_HASHES_DEF; i++)
      send(with_func(a, FUNC_READ, flow_scoreboard::entry_of(a, i)));
    send(with_func(random_flow(FUNC_REMOVE), FUNC_REMOVE, 0));
    send(with_func(z, FUNC_READ, TBL_ENTRIES));
    send(with_func(z, FUNC_READ, 4095));
    send(with_func(a, FUNC_READ, 4095));

    // Many new flows on one entry of the first sub-table drive its flow count
    // into saturation.
    while (hot_flows < 270) begin
      c = random_flow(FUNC_UPDATE);
      if (flow_scoreboard::hash_of(c, 0) % SUB_TABLE_DEPTH_DEF == 0) begin
        send(c);
        hot_flows++;
        if (hot_flows % 90 == 0) send(with_func(z, FUNC_READ, 0));
      end
    end
    send(with_func(z, FUNC_READ, 0));

    for (int i = 0; i < 64; i++) pool[i] = random_flow(FUNC_UPDATE);
    for (int n = 0; n < 860; n++) begin
      calm = (n >= 300 && n < 450);
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, 63)] = random_flow(FUNC_UPDATE);
      c = pool[$urandom_range(0, 63)];
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        c = random_flow(func_t'($urandom_range(0, 3)));
      end else if (pick < 50) begin
        c = with_func(c, FUNC_UPDATE, 0);
      end else if (pick < 65) begin
        c = with_func(c, FUNC_QUERY, 0);
      end else if (pick < 75) begin
        c = with_func(c, FUNC_REMOVE, 0);
      end else if (pick < 92) begin
        c = with_func(c, FUNC_READ,
                      flow_scoreboard::entry_of(c, $urandom_range(0, TABLE_HASHES_DEF - 1)));
      end else begin
        c = with_func(c, FUNC_READ, $urandom_range(0, 4095));
      end
      send(c);
    end
    calm = 1'b0;
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d commands and checked %0d results, including %0d new flows on one",
             sent, sb.checked, hot_flows);
    $display("entry for saturation, removals below zero and out-of-range reads.");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timed out with %0d results outstanding.", sb.pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
